[sv/gbfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared types and constants of the binary GPS frame parser.
// ----------------------------------------------------------------------------
package gbfp_pkg;

	localparam int MAX_PAYLOAD_DEF = 64;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_A_V14 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_B_V14 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_V14  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NAV_ID_V14 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_V14 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_V16 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_NAV_ID_V16 = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_OVERRUN  = 3'd1;
	localparam logic [2:0] ERR_TOO_LONG = 3'd2;
	localparam logic [2:0] ERR_CHECKSUM = 3'd3;
	localparam logic [2:0] ERR_UNEXPECT = 3'd4;
	localparam logic [2:0] ERR_SYNC     = 3'd5;

	typedef struct packed {
		logic [7:0] sync_a_v14;
		logic [7:0] sync_b_v14;
		logic [7:0] class_v14;
		logic [7:0] nav_id_v14;
		logic [6:0] length_v14;
		logic [7:0] header_v16;
		logic [7:0] nav_id_v16;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        payload_valid;
		logic [5:0]  payload_index;
		logic        frame_good;
		logic        frame_error;
		logic [2:0]  error_code;
		logic [15:0] error_count;
		logic        format_v16;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
	} res_t;

endpackage
`default_nettype wire

[sv/gbfp_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_in_if
// Received byte channel: valid/ready handshake with byte and busy flag.
// ----------------------------------------------------------------------------
interface gbfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       downstream_busy;

	modport source (output valid, output rx_byte, output downstream_busy, input ready);
	modport sink   (input valid, input rx_byte, input downstream_busy, output ready);
endinterface
`default_nettype wire

[sv/gbfp_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_out_if
// Result channel: valid/ready handshake with one parser result per byte.
// ----------------------------------------------------------------------------
interface gbfp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        payload_valid;
	logic [5:0]  payload_index;
	logic        frame_good;
	logic        frame_error;
	logic [2:0]  error_code;
	logic [15:0] error_count;
	logic        format_v16;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;

	modport source (
		output valid, output data_byte, output payload_valid, output payload_index,
		output frame_good, output frame_error, output error_code, output error_count,
		output format_v16, output frame_class, output frame_id, input ready
	);
	modport sink (
		input valid, input data_byte, input payload_valid, input payload_index,
		input frame_good, input frame_error, input error_code, input error_count,
		input format_v16, input frame_class, input frame_id, output ready
	);
endinterface
`default_nettype wire

[sv/gbfp_parse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_parse
// Frame state machine: parser state registers and the per-byte update.
// ----------------------------------------------------------------------------
module gbfp_parse
	import gbfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic       busy,
	input  wire cfg_t       cfg,
	output res_t            res
);

	localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'd0,
		ST_S1_14 = 4'd1,
		ST_S2_14 = 4'd2,
		ST_CL_14 = 4'd3,
		ST_H_16  = 4'd4,
		ST_ID_16 = 4'd5,
		ST_PAY   = 4'd6,
		ST_CK1   = 4'd7,
		ST_CK2   = 4'd8
	} state_t;

	state_t                 state_q, state_d;
	logic [7:0]             ck_a_q, ck_a_d, ck_b_q, ck_b_d;
	logic [7:0]             len_q, len_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [7:0]             class_q, class_d, id_q, id_d;
	logic                   fmt_q, fmt_d;
	logic [2:0]             err_q, err_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

	logic [7:0] sum_a, sum_b, hdr_len;
	logic [8:0] idx_inc;
	logic       ok, good, pvalid;

	assign sum_a   = ck_a_q + rx_byte;
	assign sum_b   = ck_b_q + sum_a;
	assign idx_inc = 9'(idx_q) + 9'd1;
	// length that enters the payload: fixed for 1.4, the byte itself for 1.6
	assign hdr_len = (state_q == ST_ID_16) ? rx_byte : len_q;

	always_comb begin
		state_d = state_q;
		ck_a_d  = ck_a_q;
		ck_b_d  = ck_b_q;
		len_d   = len_q;
		idx_d   = idx_q;
		class_d = class_q;
		id_d    = id_q;
		fmt_d   = fmt_q;
		err_d   = err_q;
		ok      = 1'b1;
		good    = 1'b0;
		pvalid  = 1'b0;

		// header and payload bytes feed the running checksum
		if (state_q inside {ST_IDLE, ST_S1_14, ST_S2_14, ST_CL_14, ST_H_16, ST_ID_16,
				ST_PAY}) begin
			ck_a_d = sum_a;
			ck_b_d = sum_b;
		end

		case (state_q)
			ST_IDLE: begin
				if (rx_byte == cfg.sync_a_v14) begin
					fmt_d   = 1'b0;
					state_d = ST_S1_14;
				end else if (rx_byte == cfg.header_v16) begin
					fmt_d   = 1'b1;
					class_d = rx_byte;
					state_d = ST_H_16;
				end
			end
			ST_S1_14: begin
				if (rx_byte != cfg.sync_b_v14) begin
					err_d = ERR_SYNC;
					ok    = 1'b0;
				end else if (busy) begin
					err_d = ERR_OVERRUN;
					ok    = 1'b0;
				end else begin
					ck_a_d  = '0;
					ck_b_d  = '0;
					len_d   = 8'(cfg.length_v14);
					state_d = ST_S2_14;
				end
			end
			ST_S2_14: begin
				if (rx_byte != cfg.class_v14) begin
					err_d = ERR_SYNC;
					ok    = 1'b0;
				end else begin
					class_d = rx_byte;
					idx_d   = '0;
					state_d = ST_CL_14;
				end
			end
			ST_CL_14, ST_ID_16: begin
				if (state_q == ST_CL_14 && rx_byte != cfg.nav_id_v14) begin
					err_d = ERR_SYNC;
					ok    = 1'b0;
				end else begin
					if (state_q == ST_CL_14) begin
						id_d = rx_byte;
					end
					len_d = hdr_len;
					idx_d = '0;
					if (9'(hdr_len) > 9'(MAX_PAYLOAD)) begin
						err_d = ERR_TOO_LONG;
						ok    = 1'b0;
					end else begin
						state_d = (hdr_len == 8'd0) ? ST_CK1 : ST_PAY;
					end
				end
			end
			ST_H_16: begin
				if (rx_byte != cfg.nav_id_v16) begin
					err_d = ERR_SYNC;
					ok    = 1'b0;
				end else if (busy) begin
					err_d = ERR_OVERRUN;
					ok    = 1'b0;
				end else begin
					id_d    = rx_byte;
					ck_a_d  = '0;
					ck_b_d  = '0;
					state_d = ST_ID_16;
				end
			end
			ST_PAY: begin
				pvalid = 1'b1;
				idx_d  = IDX_W'(idx_inc);
				if (idx_inc >= 9'(len_q)) begin
					state_d = ST_CK1;
				end
			end
			ST_CK1: begin
				if (rx_byte != ck_a_q) begin
					err_d = ERR_CHECKSUM;
					ok    = 1'b0;
				end else begin
					state_d = ST_CK2;
				end
			end
			ST_CK2: begin
				if (rx_byte != ck_b_q) begin
					err_d = ERR_CHECKSUM;
					ok    = 1'b0;
				end else begin
					good    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				err_d = ERR_UNEXPECT;
				ok    = 1'b0;
			end
		endcase

		cnt_d = cnt_q;
		if (!ok) begin
			cnt_d   = cnt_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ck_a_q  <= '0;
			ck_b_q  <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			class_q <= '0;
			id_q    <= '0;
			fmt_q   <= 1'b0;
			err_q   <= ERR_NONE;
			cnt_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			ck_a_q  <= ck_a_d;
			ck_b_q  <= ck_b_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			class_q <= class_d;
			id_q    <= id_d;
			fmt_q   <= fmt_d;
			err_q   <= err_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		res.data_byte     = pvalid ? rx_byte : 8'd0;
		res.payload_valid = pvalid;
		res.payload_index = pvalid ? 6'(idx_q) : 6'd0;
		res.frame_good    = good;
		res.frame_error   = !ok;
		res.error_code    = err_d;
		res.error_count   = 16'(cnt_d);
		res.format_v16    = fmt_d;
		res.frame_class   = class_d;
		res.frame_id      = id_d;
	end

endmodule
`default_nettype wire

[sv/gps_binary_frame_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gps_binary_frame_parser
// Byte-wise parser for 1.4 and 1.6 binary GPS frames with Fletcher checksum.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      carries
//  rx_chan   in   valid/ready    rx_byte, downstream_busy
//  result    out  valid/ready    payload echo, frame status, error info
//  cfg_*     in   cfg_we only    register index + 8-bit data, no read-back
//
//  The frame state machine updates on the transaction and the result lands in
//  the output register on the same edge, which drives result. A full output
//  register that is being drained still takes a new byte, so bytes stream at
//  one per clock; rx_chan.ready drops only while a result is held and
//  result.ready is low. arst_n clears the parser to idle, zero checksums and
//  count, and loads register defaults.
// ----------------------------------------------------------------------------
module gps_binary_frame_parser
	import gbfp_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	gbfp_in_if.sink                    rx_chan,
	gbfp_out_if.source                 result
);

	cfg_t cfg_q;
	res_t res_d, res_q;
	logic out_valid_q;
	logic take;

	// --- configuration registers -------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_a_v14 <= 8'd181;
			cfg_q.sync_b_v14 <= 8'd98;
			cfg_q.class_v14  <= 8'd1;
			cfg_q.nav_id_v14 <= 8'd5;
			cfg_q.length_v14 <= 7'd32;
			cfg_q.header_v16 <= 8'd208;
			cfg_q.nav_id_v16 <= 8'd221;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_A_V14: cfg_q.sync_a_v14 <= cfg_wdata;
				CFG_SYNC_B_V14: cfg_q.sync_b_v14 <= cfg_wdata;
				CFG_CLASS_V14:  cfg_q.class_v14  <= cfg_wdata;
				CFG_NAV_ID_V14: cfg_q.nav_id_v14 <= cfg_wdata;
				CFG_LENGTH_V14: cfg_q.length_v14 <= cfg_wdata[6:0];
				CFG_HEADER_V16: cfg_q.header_v16 <= cfg_wdata;
				CFG_NAV_ID_V16: cfg_q.nav_id_v16 <= cfg_wdata;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// --- input handshake ---------------------------------------------------
	// accept whenever the output slot is free or drains this cycle
	assign rx_chan.ready = !out_valid_q || result.ready;
	assign take          = rx_chan.valid && rx_chan.ready;

	// --- frame state machine -----------------------------------------------
	gbfp_parse #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (take),
		.rx_byte (rx_chan.rx_byte),
		.busy    (rx_chan.downstream_busy),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	// --- output register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.data_byte     = res_q.data_byte;
	assign result.payload_valid = res_q.payload_valid;
	assign result.payload_index = res_q.payload_index;
	assign result.frame_good    = res_q.frame_good;
	assign result.frame_error   = res_q.frame_error;
	assign result.error_code    = res_q.error_code;
	assign result.error_count   = res_q.error_count;
	assign result.format_v16    = res_q.format_v16;
	assign result.frame_class   = res_q.frame_class;
	assign result.frame_id      = res_q.frame_id;

endmodule
`default_nettype wire
